>>> rtl/bmpu_pkg.sv
`default_nettype none
package bmpu_pkg;

    localparam int TRIG_ITERATIONS_DEF = 16;
    localparam int ATAN_TBL_LEN        = 24;
    localparam int ATAN_IDX_W          = 5;

    // Shared multiplier: A operand signed, B operand signed, one B bit per cycle.
    localparam int MUL_A_W = 72;
    localparam int MUL_B_W = 32;
    localparam int MUL_P_W = MUL_A_W + 1 + MUL_B_W;
    localparam int MUL_CNT_W = $clog2(MUL_B_W);

    // CORDIC datapath width, Q30 values with guard bits.
    localparam int CRD_W = 34;
    localparam logic signed [CRD_W-1:0] CORDIC_GAIN = 34'sd652032874;

    localparam logic [31:0] RAD_Q16_TO_BAM = 32'd683565276;
    localparam logic signed [17:0] WHEEL_LIMIT = 18'sd91750;

    // Configuration register indexes
    localparam logic [1:0] REG_INV_STEER_RATIO = 2'd0;
    localparam logic [1:0] REG_INV_WHEEL_BASE  = 2'd1;
    localparam logic [1:0] REG_TIME_STEP       = 2'd2;

    localparam logic [15:0] INV_STEER_RATIO_RST = 16'd4096;
    localparam logic [15:0] INV_WHEEL_BASE_RST  = 16'd23405;
    localparam logic [15:0] TIME_STEP_RST       = 16'd655;

    typedef logic signed [CRD_W-1:0] crd_word_t;

    function automatic crd_word_t atan_entry(input logic [ATAN_IDX_W-1:0] idx);
        crd_word_t v;
        case (idx)
            5'd0:    v = 34'sh020000000;
            5'd1:    v = 34'sh012E4051E;
            5'd2:    v = 34'sh009FB385B;
            5'd3:    v = 34'sh0051111D4;
            5'd4:    v = 34'sh0028B0D43;
            5'd5:    v = 34'sh00145D7E1;
            5'd6:    v = 34'sh000A2F61E;
            5'd7:    v = 34'sh000517C55;
            5'd8:    v = 34'sh00028BE53;
            5'd9:    v = 34'sh000145F2F;
            5'd10:   v = 34'sh0000A2F98;
            5'd11:   v = 34'sh0000517CC;
            5'd12:   v = 34'sh000028BE6;
            5'd13:   v = 34'sh0000145F3;
            5'd14:   v = 34'sh00000A2FA;
            5'd15:   v = 34'sh00000517D;
            5'd16:   v = 34'sh0000028BE;
            5'd17:   v = 34'sh00000145F;
            5'd18:   v = 34'sh000000A30;
            5'd19:   v = 34'sh000000518;
            5'd20:   v = 34'sh00000028C;
            5'd21:   v = 34'sh000000146;
            5'd22:   v = 34'sh0000000A3;
            5'd23:   v = 34'sh000000051;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage
`default_nettype wire

>>> rtl/bmpu_mul.sv
`default_nettype none
module bmpu_mul
    import bmpu_pkg::*;
(
    input  wire                              aclk,
    input  wire                              aresetn,
    input  wire                              start,
    input  wire logic signed [MUL_A_W-1:0]   op_a,
    input  wire logic signed [MUL_B_W-1:0]   op_b,
    output logic                             done,
    output logic signed [MUL_P_W-1:0]        prod
);

    logic signed [MUL_A_W-1:0] a_reg;
    logic signed [MUL_A_W:0]   p_reg, p_next;
    logic [MUL_B_W-1:0]        q_reg, q_next;
    logic [MUL_CNT_W-1:0]      cnt_reg;
    logic                      busy_reg, done_reg;
    logic signed [MUL_A_W+1:0] addend, sum;
    logic                      last;

    assign last = (cnt_reg == MUL_CNT_W'(MUL_B_W - 1));

    always_comb begin
        // sign bit of B carries negative weight
        if (q_reg[0]) begin
            addend = last ? -(MUL_A_W+2)'(a_reg) : (MUL_A_W+2)'(a_reg);
        end else begin
            addend = '0;
        end
        sum    = (MUL_A_W+2)'(p_reg) + addend;
        p_next = sum[MUL_A_W+1:1];
        q_next = {sum[0], q_reg[MUL_B_W-1:1]};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= busy_reg && last;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + 1'b1;
                if (last) busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            a_reg <= op_a;
            p_reg <= '0;
            q_reg <= op_b;
        end else if (busy_reg) begin
            p_reg <= p_next;
            q_reg <= q_next;
        end
    end

    assign done = done_reg;
    assign prod = {p_reg, q_reg};

endmodule
`default_nettype wire

>>> rtl/bmpu_cordic.sv
`default_nettype none
module bmpu_cordic
    import bmpu_pkg::*;
#(
    parameter int ITER = TRIG_ITERATIONS_DEF
) (
    input  wire               aclk,
    input  wire               aresetn,
    input  wire               start,
    input  wire logic [31:0]  angle,
    output logic              done,
    output crd_word_t         cos_q30,
    output crd_word_t         sin_q30
);

    localparam int IW = (ITER > 1) ? $clog2(ITER) : 1;

    crd_word_t       x_reg, y_reg, z_reg, cos_reg, sin_reg;
    logic [IW-1:0]   i_reg;
    logic            busy_reg, done_reg, flip_reg;
    logic            last;
    logic            flip_in;
    logic [31:0]     ang_adj;
    crd_word_t       ys, xs, at;

    assign last    = (i_reg == IW'(ITER - 1));
    assign flip_in = angle[31] ^ angle[30];
    assign ang_adj = flip_in ? {~angle[31], angle[30:0]} : angle;

    always_comb begin
        ys = y_reg >>> i_reg;
        xs = x_reg >>> i_reg;
        at = atan_entry(ATAN_IDX_W'(i_reg));
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            i_reg    <= '0;
        end else begin
            done_reg <= busy_reg && last;
            if (start) begin
                busy_reg <= 1'b1;
                i_reg    <= '0;
            end else if (busy_reg) begin
                i_reg <= i_reg + 1'b1;
                if (last) busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            x_reg    <= CORDIC_GAIN;
            y_reg    <= '0;
            z_reg    <= CRD_W'($signed(ang_adj));
            flip_reg <= flip_in;
        end else if (busy_reg) begin
            if (!z_reg[CRD_W-1]) begin
                x_reg <= x_reg - ys;
                y_reg <= y_reg + xs;
                z_reg <= z_reg - at;
            end else begin
                x_reg <= x_reg + ys;
                y_reg <= y_reg - xs;
                z_reg <= z_reg + at;
            end
        end
        if (busy_reg && last) begin
            // results of the final step are not yet in x_reg, so fold them here
            if (!z_reg[CRD_W-1]) begin
                cos_reg <= flip_reg ? -(x_reg - ys) : (x_reg - ys);
                sin_reg <= flip_reg ? -(y_reg + xs) : (y_reg + xs);
            end else begin
                cos_reg <= flip_reg ? -(x_reg + ys) : (x_reg + ys);
                sin_reg <= flip_reg ? -(y_reg - xs) : (y_reg - xs);
            end
        end
    end

    assign done    = done_reg;
    assign cos_q30 = cos_reg;
    assign sin_q30 = sin_reg;

endmodule
`default_nettype wire

>>> rtl/bicycle_model_pose_update.sv
// Pose update, one item in work at a time on a single sequencer.
// Load item: the accept edge stores the pose and moves to S_FIN, which fills the result register.
// Integrate item: the result is offered after ten bit-serial multiplies, two CORDIC runs and a
// 50-step restoring divide. Input reopens on the edge that loads the result register;
// a stalled result holds the sequencer. Reset (aresetn low, synchronous) clears the pose.
`default_nettype none
module bicycle_model_pose_update
    import bmpu_pkg::*;
#(
    parameter int TRIG_ITERATIONS = TRIG_ITERATIONS_DEF
) (
    input  wire                aclk,
    input  wire                aresetn,
    // Step item input
    input  wire                s_tvalid,
    output logic               s_tready,
    input  wire logic [111:0]  s_tdata,  // speed, steer_angle, load_x, load_y, load_heading
    input  wire logic          s_tuser,  // req_type
    // Pose result output
    output logic               m_tvalid,
    input  wire                m_tready,
    output logic [79:0]        m_tdata,  // pos_x, pos_y, heading
    // Configuration writes
    input  wire                cfg_we,
    input  wire logic [1:0]    cfg_addr,
    input  wire logic [15:0]   cfg_wdata
);

    localparam logic [4:0] S_IDLE = 5'd0,  S_M1  = 5'd1,  S_M2  = 5'd2,  S_C1  = 5'd3,
                           S_DI   = 5'd4,  S_DR  = 5'd5,  S_M3  = 5'd6,  S_M4  = 5'd7,
                           S_M5   = 5'd8,  S_M6  = 5'd9,  S_C2  = 5'd10, S_M7  = 5'd11,
                           S_M8   = 5'd12, S_M9  = 5'd13, S_M10 = 5'd14, S_FIN = 5'd15;

    localparam int DIV_W = 50;

    // configuration
    logic [15:0] isr_reg, iwb_reg, ts_reg;

    // pose and item fields
    logic signed [31:0] px_reg, py_reg;
    logic [15:0]        ph_reg;
    logic signed [15:0] speed_reg, steer_reg;

    logic [4:0]         state_reg;
    logic               wait_reg;
    logic signed [MUL_A_W-1:0] tmp_reg;
    logic [31:0]        ang_reg;
    crd_word_t          wc_reg, ws_reg;

    // divider
    logic [DIV_W-1:0]   q_reg;
    logic [CRD_W-1:0]   rem_reg;
    logic [5:0]         dcnt_reg;

    logic               m_valid_reg;
    logic [79:0]        m_data_reg;

    // multiplier hookup
    logic                      mul_state, mul_start, mul_done;
    logic signed [MUL_A_W-1:0] mul_a;
    logic signed [MUL_B_W-1:0] mul_b;
    logic signed [MUL_P_W-1:0] mul_p;
    logic signed [MUL_A_W-1:0] p72;
    logic signed [MUL_A_W-1:0] tanq;

    logic      crd_state, crd_start, crd_done;
    crd_word_t crd_cos, crd_sin;

    assign mul_state = (state_reg == S_M1) || (state_reg == S_M2) || (state_reg == S_M3)
                    || (state_reg == S_M4) || (state_reg == S_M5) || (state_reg == S_M6)
                    || (state_reg == S_M7) || (state_reg == S_M8) || (state_reg == S_M9)
                    || (state_reg == S_M10);
    assign crd_state = (state_reg == S_C1) || (state_reg == S_C2);
    assign mul_start = mul_state && !wait_reg;
    assign crd_start = crd_state && !wait_reg;

    // operand selection per step
    always_comb begin
        mul_a = tmp_reg;
        mul_b = MUL_B_W'($signed({1'b0, ts_reg}));
        unique case (state_reg)
            S_M1: begin
                mul_a = MUL_A_W'(steer_reg);
                mul_b = MUL_B_W'($signed({1'b0, isr_reg}));
            end
            S_M2, S_M6: mul_b = MUL_B_W'($signed({1'b0, RAD_Q16_TO_BAM}));
            S_M3, S_M9: begin
                // tangent straight from the held quotient, sign taken from the sine
                mul_a = (state_reg == S_M9) ? MUL_A_W'(ws_reg) : tanq;
                mul_b = MUL_B_W'(speed_reg);
            end
            S_M4: mul_b = MUL_B_W'($signed({1'b0, iwb_reg}));
            S_M7: begin
                mul_a = MUL_A_W'(wc_reg);
                mul_b = MUL_B_W'(speed_reg);
            end
            default: ;
        endcase
    end

    bmpu_mul u_mul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (mul_start),
        .op_a    (mul_a),
        .op_b    (mul_b),
        .done    (mul_done),
        .prod    (mul_p)
    );

    bmpu_cordic #(.ITER(TRIG_ITERATIONS)) u_cordic (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (crd_start),
        .angle   (ang_reg),
        .done    (crd_done),
        .cos_q30 (crd_cos),
        .sin_q30 (crd_sin)
    );

    // rounded shifts of the product, ties toward plus infinity
    logic signed [MUL_A_W-1:0] rnd11, rnd16, rnd24, rnd38;
    logic [MUL_A_W-1:0]        bam16, bam32;
    logic signed [17:0]        wheel;
    logic signed [35:0]        sx_sum;
    logic signed [31:0]        sat_out;
    logic signed [31:0]        pose_sel;

    assign p72 = mul_p[MUL_A_W-1:0];

    always_comb begin
        rnd11 = (p72 + (MUL_A_W'(1) <<< 10)) >>> 11;
        rnd16 = (p72 + (MUL_A_W'(1) <<< 15)) >>> 16;
        rnd24 = (p72 + (MUL_A_W'(1) <<< 23)) >>> 24;
        rnd38 = (p72 + (MUL_A_W'(1) <<< 37)) >>> 38;
        bam16 = p72 + (MUL_A_W'(1) << 15);
        bam32 = p72 + (MUL_A_W'(1) << 31);
        // clamp the road-wheel angle to about 1.4 rad
        if (rnd11 > MUL_A_W'(WHEEL_LIMIT)) begin
            wheel = WHEEL_LIMIT;
        end else if (rnd11 < -MUL_A_W'(WHEEL_LIMIT)) begin
            wheel = -WHEEL_LIMIT;
        end else begin
            wheel = rnd11[17:0];
        end
        pose_sel = (state_reg == S_M8) ? px_reg : py_reg;
        sx_sum   = 36'(pose_sel) + 36'($signed(rnd38[33:0]));
        // saturate position to the signed 32-bit range
        if (sx_sum > 36'sh07FFFFFFF) begin
            sat_out = 32'sh7FFFFFFF;
        end else if (sx_sum < -36'sh080000000) begin
            sat_out = -32'sh80000000;
        end else begin
            sat_out = sx_sum[31:0];
        end
    end

    // restoring divide step
    logic [CRD_W:0]   trial;
    logic [CRD_W:0]   diff;
    logic             ws_neg;
    logic [CRD_W-1:0] ws_mag;

    assign ws_neg = ws_reg[CRD_W-1];
    assign ws_mag = ws_neg ? CRD_W'(-ws_reg) : CRD_W'(ws_reg);
    assign trial  = {rem_reg, q_reg[DIV_W-1]};
    assign diff   = trial - {1'b0, wc_reg};
    // quotient magnitude truncated toward zero, then signed by the sine
    assign tanq   = ws_neg ? -MUL_A_W'($signed({1'b0, q_reg}))
                           :  MUL_A_W'($signed({1'b0, q_reg}));

    assign s_tready = (state_reg == S_IDLE);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            wait_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
            isr_reg     <= INV_STEER_RATIO_RST;
            iwb_reg     <= INV_WHEEL_BASE_RST;
            ts_reg      <= TIME_STEP_RST;
            px_reg      <= '0;
            py_reg      <= '0;
            ph_reg      <= '0;
            dcnt_reg    <= '0;
        end else begin
            if (cfg_we) begin
                case (cfg_addr)
                    REG_INV_STEER_RATIO: isr_reg <= cfg_wdata;
                    REG_INV_WHEEL_BASE:  iwb_reg <= cfg_wdata;
                    REG_TIME_STEP:       ts_reg  <= cfg_wdata;
                    default: ;
                endcase
            end

            // drop the taken result unless a new one is loaded on the same edge
            if (m_valid_reg && m_tready && (state_reg != S_FIN)) m_valid_reg <= 1'b0;

            // issue a unit start once per step, then hold until it reports done
            if ((mul_state || crd_state) && !wait_reg) wait_reg <= 1'b1;

            unique case (state_reg)
                S_IDLE: begin
                    if (s_tvalid) begin
                        speed_reg <= s_tdata[15:0];
                        steer_reg <= s_tdata[31:16];
                        if (s_tuser) begin
                            px_reg    <= s_tdata[63:32];
                            py_reg    <= s_tdata[95:64];
                            ph_reg    <= s_tdata[111:96];
                            state_reg <= S_FIN;
                        end else begin
                            state_reg <= S_M1;
                        end
                    end
                end
                S_M1: if (mul_done) begin
                    tmp_reg   <= MUL_A_W'(wheel);
                    wait_reg  <= 1'b0;
                    state_reg <= S_M2;
                end
                S_M2: if (mul_done) begin
                    ang_reg   <= bam16[47:16];
                    wait_reg  <= 1'b0;
                    state_reg <= S_C1;
                end
                S_C1: if (crd_done) begin
                    // keep the divisor at least one LSB
                    wc_reg    <= (crd_cos < 34'sd1) ? 34'sd1 : crd_cos;
                    ws_reg    <= crd_sin;
                    wait_reg  <= 1'b0;
                    state_reg <= S_DI;
                end
                S_DI: begin
                    q_reg     <= {ws_mag, 16'h0};
                    rem_reg   <= '0;
                    dcnt_reg  <= '0;
                    state_reg <= S_DR;
                end
                S_DR: begin
                    if (!diff[CRD_W]) begin
                        rem_reg <= diff[CRD_W-1:0];
                        q_reg   <= {q_reg[DIV_W-2:0], 1'b1};
                    end else begin
                        rem_reg <= trial[CRD_W-1:0];
                        q_reg   <= {q_reg[DIV_W-2:0], 1'b0};
                    end
                    dcnt_reg <= dcnt_reg + 1'b1;
                    if (dcnt_reg == 6'(DIV_W - 1)) state_reg <= S_M3;
                end
                S_M3: if (mul_done) begin
                    tmp_reg   <= p72;
                    wait_reg  <= 1'b0;
                    state_reg <= S_M4;
                end
                S_M4: if (mul_done) begin
                    tmp_reg   <= rnd16;
                    wait_reg  <= 1'b0;
                    state_reg <= S_M5;
                end
                S_M5: if (mul_done) begin
                    tmp_reg   <= rnd24;
                    wait_reg  <= 1'b0;
                    state_reg <= S_M6;
                end
                S_M6: if (mul_done) begin
                    ph_reg    <= ph_reg + bam32[47:32];
                    ang_reg   <= {ph_reg + bam32[47:32], 16'h0};
                    wait_reg  <= 1'b0;
                    state_reg <= S_C2;
                end
                S_C2: if (crd_done) begin
                    wc_reg    <= crd_cos;
                    ws_reg    <= crd_sin;
                    wait_reg  <= 1'b0;
                    state_reg <= S_M7;
                end
                S_M7: if (mul_done) begin
                    tmp_reg   <= p72;
                    wait_reg  <= 1'b0;
                    state_reg <= S_M8;
                end
                S_M8: if (mul_done) begin
                    px_reg    <= sat_out;
                    wait_reg  <= 1'b0;
                    state_reg <= S_M9;
                end
                S_M9: if (mul_done) begin
                    tmp_reg   <= p72;
                    wait_reg  <= 1'b0;
                    state_reg <= S_M10;
                end
                S_M10: if (mul_done) begin
                    py_reg    <= sat_out;
                    wait_reg  <= 1'b0;
                    state_reg <= S_FIN;
                end
                S_FIN: begin
                    // hold until the result register is free
                    if (!m_valid_reg || m_tready) begin
                        m_data_reg  <= {ph_reg, py_reg, px_reg};
                        m_valid_reg <= 1'b1;
                        state_reg   <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    // Checks
    a_mul_done_waiting: assert property (@(posedge aclk) disable iff (!aresetn)
        mul_done |-> (mul_state && wait_reg))
        else $error("multiplier finished outside a multiply step");

    a_crd_done_waiting: assert property (@(posedge aclk) disable iff (!aresetn)
        crd_done |-> (crd_state && wait_reg))
        else $error("CORDIC finished outside a trig step");

    a_load_to_fin: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && s_tuser) |=> (state_reg == S_FIN))
        else $error("load item did not go straight to result");

endmodule
`default_nettype wire
